FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge.
`define CHK_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define CHK_DELAY(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("delayed check failed");

`endif

FILE: src/lqrs_pkg.sv
package lqrs_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// magnitude of a word, up to 2^(W-1)
	localparam int MAG_W = WORD_BITS;
	// b*b and 4ac, plus headroom for their sum
	localparam int PROD_W = 2 * WORD_BITS + 2;
	localparam int SQ_W = PROD_W / 2;
	localparam int SQ_REM_W = SQ_W + 2;
	localparam int NUM_W = WORD_BITS + 2;
	localparam int DEN_W = WORD_BITS + 1;
	localparam int NUMS_W = NUM_W + FRAC_BITS;
	localparam int DV_REM_W = DEN_W + 1;
	localparam int Q_W = WORD_BITS + 1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOREAL = 2'd1;
	localparam logic [1:0] ST_NOROOT = 2'd2;
	localparam logic [1:0] ST_DIVZ = 2'd3;

	localparam logic [1:0] SEL_PLUS = 2'd1;
	localparam logic [1:0] SEL_MINUS = 2'd2;

	localparam logic KIND_LIN = 1'b0;

	typedef struct packed {
		logic kind;
		logic signed [WORD_BITS-1:0] coef_a;
		logic signed [WORD_BITS-1:0] coef_b;
		logic signed [WORD_BITS-1:0] coef_c;
		logic [1:0] root_select;
	} in_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] root;
		logic [1:0] status;
	} out_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [SQ_W-1:0] root;
		logic [PROD_W-1:0] rad;
	} sq_cell_t;

	typedef struct packed {
		logic [DV_REM_W-1:0] rem;
		logic [Q_W-1:0] q;
		logic ovf;
		logic [NUMS_W-1:0] num;
		logic [DEN_W-1:0] den;
	} dv_cell_t;

endpackage

FILE: src/lqrs_sqrt_cell.sv
module lqrs_sqrt_cell (
	input  logic clk,
	input  lqrs_pkg::sq_cell_t d,
	output lqrs_pkg::sq_cell_t q
);

	logic [lqrs_pkg::SQ_REM_W-1:0] rem_t;
	logic [lqrs_pkg::SQ_REM_W-1:0] trial;
	logic ge;

	// bring down the next two radicand bits, try root*4+1
	assign rem_t = {d.rem[lqrs_pkg::SQ_REM_W-3:0], d.rad[lqrs_pkg::PROD_W-1 -: 2]};
	assign trial = {d.root, 2'b01};
	assign ge = (rem_t >= trial);

	always_ff @(posedge clk) begin
		q.rem <= ge ? (rem_t - trial) : rem_t;
		q.root <= {d.root[lqrs_pkg::SQ_W-2:0], ge};
		q.rad <= {d.rad[lqrs_pkg::PROD_W-3:0], 2'b00};
	end

endmodule

FILE: src/lqrs_div_cell.sv
module lqrs_div_cell (
	input  logic clk,
	input  lqrs_pkg::dv_cell_t d,
	output lqrs_pkg::dv_cell_t q
);

	logic [lqrs_pkg::DV_REM_W-1:0] rem_t;
	logic [lqrs_pkg::DV_REM_W-1:0] den_x;
	logic ge;

	assign rem_t = {d.rem[lqrs_pkg::DV_REM_W-2:0], d.num[lqrs_pkg::NUMS_W-1]};
	assign den_x = {1'b0, d.den};
	assign ge = (rem_t >= den_x);

	always_ff @(posedge clk) begin
		q.rem <= ge ? (rem_t - den_x) : rem_t;
		q.q <= {d.q[lqrs_pkg::Q_W-2:0], ge};
		// a bit shifted out of the kept quotient means saturation
		q.ovf <= d.ovf | d.q[lqrs_pkg::Q_W-1];
		q.num <= {d.num[lqrs_pkg::NUMS_W-2:0], 1'b0};
		q.den <= d.den;
	end

endmodule

FILE: src/linear_quadratic_root_solver.sv
// An equation passes through stage 1, stage 2, the square-root row, the divider row and
// the output stage, all registered; the result word comes out together with done.
// Throughput: one equation per cycle; busy stays low, start is always taken.
// The square-root row and the divider row each work out one bit per cell.
// Reset clears only the valid bits; the data path needs no reset.
// The receiver cannot stall: done strobes for one cycle per equation.
`include "assert_macros.svh"

module linear_quadratic_root_solver (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  lqrs_pkg::in_t eq,
	output logic done,
	output lqrs_pkg::out_t sol
);

	localparam int W = lqrs_pkg::WORD_BITS;
	localparam int MW = lqrs_pkg::MAG_W;
	localparam int PW = lqrs_pkg::PROD_W;
	localparam int SQ = lqrs_pkg::SQ_W;
	localparam int DS = lqrs_pkg::NUMS_W;
	localparam int LAT = 5 + SQ + DS;

	typedef struct packed {
		logic kind;
		logic [1:0] sel;
		logic [1:0] status;
		logic sa;
		logic [MW-1:0] ma;
		logic sb;
		logic [MW-1:0] mb;
		logic sc;
		logic [MW-1:0] mc;
	} side_t;

	typedef struct packed {
		logic [1:0] status;
		logic neg;
	} dside_t;

	assign busy = 1'b0;

	// stage 1: split into sign and magnitude
	logic v_s1;
	logic kind_s1;
	logic [1:0] sel_s1;
	logic sa_s1, sb_s1, sc_s1;
	logic [MW-1:0] ma_s1, mb_s1, mc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= eq.kind;
		sel_s1 <= eq.root_select;
		sa_s1 <= eq.coef_a[W-1];
		sb_s1 <= eq.coef_b[W-1];
		sc_s1 <= eq.coef_c[W-1];
		ma_s1 <= eq.coef_a[W-1] ? (~eq.coef_a + 1'b1) : eq.coef_a;
		mb_s1 <= eq.coef_b[W-1] ? (~eq.coef_b + 1'b1) : eq.coef_b;
		mc_s1 <= eq.coef_c[W-1] ? (~eq.coef_c + 1'b1) : eq.coef_c;
	end

	// stage 2: products
	logic v_s2;
	side_t sd_s2;
	logic [2*MW-1:0] bb_s2, ac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		bb_s2 <= mb_s1 * mb_s1;
		ac_s2 <= ma_s1 * mc_s1;
		sd_s2 <= '{kind: kind_s1, sel: sel_s1, status: lqrs_pkg::ST_OK,
			sa: sa_s1, ma: ma_s1, sb: sb_s1, mb: mb_s1, sc: sc_s1, mc: mc_s1};
	end

	// stage 3: discriminant and status
	logic [PW-1:0] bb_x, fac_x, disc_c;
	logic [1:0] st_c;

	assign bb_x = {2'b00, bb_s2};
	assign fac_x = {ac_s2, 2'b00};

	always_comb begin
		disc_c = '0;
		st_c = lqrs_pkg::ST_OK;
		if (sd_s2.kind == lqrs_pkg::KIND_LIN) begin
			if (sd_s2.mb == '0) st_c = lqrs_pkg::ST_DIVZ;
		end else begin
			if (sd_s2.sa != sd_s2.sc && sd_s2.ma != '0 && sd_s2.mc != '0) begin
				disc_c = bb_x + fac_x;
			end else if (bb_x < fac_x) begin
				st_c = lqrs_pkg::ST_NOREAL;
			end else begin
				disc_c = bb_x - fac_x;
			end
			if (st_c == lqrs_pkg::ST_OK) begin
				if (sd_s2.sel != lqrs_pkg::SEL_PLUS && sd_s2.sel != lqrs_pkg::SEL_MINUS)
					st_c = lqrs_pkg::ST_NOROOT;
				else if (sd_s2.ma == '0)
					st_c = lqrs_pkg::ST_DIVZ;
			end
		end
	end

	// square-root row with its sideband
	lqrs_pkg::sq_cell_t sq [0:SQ];
	side_t sq_sb [0:SQ];
	logic sq_v [0:SQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else begin
			sq_v[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq[0] <= '{rem: '0, root: '0, rad: disc_c};
		sq_sb[0] <= '{kind: sd_s2.kind, sel: sd_s2.sel, status: st_c,
			sa: sd_s2.sa, ma: sd_s2.ma, sb: sd_s2.sb, mb: sd_s2.mb,
			sc: sd_s2.sc, mc: sd_s2.mc};
	end

	for (genvar i = 0; i < SQ; i++) begin : g_sq
		lqrs_sqrt_cell u_cell (.clk(clk), .d(sq[i]), .q(sq[i+1]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[i+1] <= 1'b0;
			end else begin
				sq_v[i+1] <= sq_v[i];
			end
		end

		always_ff @(posedge clk) begin
			sq_sb[i+1] <= sq_sb[i];
		end
	end

	// stage 4: numerator and divisor
	side_t ss;
	logic [lqrs_pkg::NUM_W-1:0] mb_n, s_n, mn_c;
	logic sn_c, sd_c, sgn_s;
	logic [lqrs_pkg::DEN_W-1:0] md_c;

	assign ss = sq_sb[SQ];
	assign mb_n = {2'b00, ss.mb};
	assign s_n = {1'b0, sq[SQ].root};
	assign sgn_s = (ss.sel == lqrs_pkg::SEL_MINUS);

	always_comb begin
		if (ss.kind == lqrs_pkg::KIND_LIN) begin
			sn_c = ~ss.sc;
			mn_c = {2'b00, ss.mc};
			sd_c = ss.sb;
			md_c = {1'b0, ss.mb};
		end else begin
			sd_c = ss.sa;
			md_c = {ss.ma, 1'b0};
			priority if (~ss.sb == sgn_s) begin
				sn_c = ~ss.sb;
				mn_c = mb_n + s_n;
			end else if (mb_n >= s_n) begin
				sn_c = ~ss.sb;
				mn_c = mb_n - s_n;
			end else begin
				sn_c = sgn_s;
				mn_c = s_n - mb_n;
			end
		end
	end

	// divider row with its sideband
	lqrs_pkg::dv_cell_t dv [0:DS];
	dside_t dv_sb [0:DS];
	logic dv_v [0:DS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else begin
			dv_v[0] <= sq_v[SQ];
		end
	end

	always_ff @(posedge clk) begin
		dv[0] <= '{rem: '0, q: '0, ovf: 1'b0,
			num: {mn_c, {lqrs_pkg::FRAC_BITS{1'b0}}}, den: md_c};
		dv_sb[0] <= '{status: ss.status, neg: sn_c ^ sd_c};
	end

	for (genvar j = 0; j < DS; j++) begin : g_dv
		lqrs_div_cell u_cell (.clk(clk), .d(dv[j]), .q(dv[j+1]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_sb[j+1] <= dv_sb[j];
		end
	end

	// output stage: sign, saturate, drop root on error
	localparam logic [lqrs_pkg::Q_W-1:0] MAXPOS = {2'b00, {(W-1){1'b1}}};
	localparam logic [lqrs_pkg::Q_W-1:0] MINMAG = {2'b01, {(W-1){1'b0}}};

	logic [lqrs_pkg::Q_W-1:0] qf, mag_c;
	logic [W-1:0] root_c;
	logic neg_f;

	assign qf = dv[DS].q;
	assign neg_f = dv_sb[DS].neg && (dv[DS].ovf || qf != '0);

	always_comb begin
		if (neg_f) begin
			mag_c = (dv[DS].ovf || qf > MINMAG) ? MINMAG : qf;
			root_c = ~mag_c[W-1:0] + 1'b1;
		end else begin
			mag_c = (dv[DS].ovf || qf > MAXPOS) ? MAXPOS : qf;
			root_c = mag_c[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_v[DS];
		end
	end

	always_ff @(posedge clk) begin
		sol.status <= dv_sb[DS].status;
		sol.root <= (dv_sb[DS].status == lqrs_pkg::ST_OK) ? root_c : '0;
	end

	`CHK_IMPL(a_err_zero, done && sol.status != lqrs_pkg::ST_OK, sol.root == '0)
	`CHK_DELAY(a_latency, start && !busy, LAT, done)
	`CHK_IMPL(a_no_phantom, done, $past(start, LAT))

endmodule
